[design/icmp_echo_responder_unit_assert.svh]
// Assertion macros used by the echo responder output queue.
// Each macro expects clk and arst_n in the scope of its use.
`ifndef ICMP_ECHO_RESPONDER_UNIT_ASSERT_SVH
`define ICMP_ECHO_RESPONDER_UNIT_ASSERT_SVH

// Expression holds at every clock edge outside reset.
`define ICMP_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ICMP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ICMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/icmp_pkg.sv]
`default_nettype none

package icmp_pkg;

	localparam int unsigned OFFSET_WIDTH_DEF = 16;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned OUTQ_DEPTH = 4;

	localparam logic [15:0] CAPACITY_RESET = 16'd1514;

	// byte offsets inside the IPv4 header
	localparam int unsigned OFF_TLEN_HI = 2;
	localparam int unsigned OFF_TLEN_LO = 3;
	localparam int unsigned OFF_SRC_FIRST = 12;
	localparam int unsigned OFF_SRC_LAST = 15;
	localparam int unsigned OFF_DST_FIRST = 16;
	localparam int unsigned OFF_DST_LAST = 19;

	localparam logic [7:0] ECHO_TYPE = 8'd8;
	localparam logic [7:0] REPLY_TYPE = 8'd0;

	localparam logic [15:0] CSUM_ADD = 16'h0800;
	localparam logic [15:0] CSUM_ADD_WRAP = 16'h0801;
	localparam logic [15:0] CSUM_WRAP_MIN = 16'hf7ff;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_OWN_IP = 1'b0,
		CFG_REPLY_CAP = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic tx_last;
		logic drop;
	} res_t;

	// up to two result items per accepted input item
	typedef struct packed {
		logic push_held;
		logic push_cur;
		res_t held;
		res_t cur;
	} wr_t;

	// byte i of a big-endian word, byte 0 being the most significant
	function automatic logic [7:0] word_byte(logic [31:0] w, logic [1:0] i);
		logic [7:0] r;
		unique case (i)
			2'd0: r = w[31:24];
			2'd1: r = w[23:16];
			2'd2: r = w[15:8];
			default: r = w[7:0];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[design/icmp_rx_if.sv]
`default_nettype none

interface icmp_rx_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;
	logic rx_last;

	modport source(output valid, output rx_byte, output rx_last, input ready);
	modport sink(input valid, input rx_byte, input rx_last, output ready);
endinterface

`default_nettype wire

[design/icmp_tx_if.sv]
`default_nettype none

interface icmp_tx_if;
	logic valid;
	logic ready;
	logic [7:0] tx_byte;
	logic tx_last;
	logic drop;

	modport source(output valid, output tx_byte, output tx_last, output drop, input ready);
	modport sink(input valid, input tx_byte, input tx_last, input drop, output ready);
endinterface

`default_nettype wire

[design/icmp_echo_responder_unit.sv]
// ICMP echo responder: rewrites a received IPv4 echo request, one byte per
// item, into the echo reply.
// rx channel: rx_byte with rx_last on the final byte of the packet.
// tx channel: tx_byte, tx_last on the final reply byte, and drop, which is
// meaningful only with tx_last and tells the sink to discard the whole reply.
// Config port: cfg_we with cfg_index 0 writes the own address (zero answers
// any destination), index 1 writes the reply capacity in bytes. Write only
// while no packet is in flight.
// Order: the reply lags by one byte. Byte n of the reply is queued at the
// edge that accepts byte n+1; the final byte is queued together with the one
// before it at the edge that accepts the last input byte. An item queued into
// an empty queue shows on tx right after that edge.
// Throughput: one byte per cycle. A four-entry output queue decouples the two
// sides; rx.ready is high while at most two items are queued, since one item
// can release up to two results. The queue read port sets the pace.
// Reset: own address 0, capacity 1514, byte offset 0, queue empty.
// When the tx sink stalls, the queue fills and rx.ready falls; nothing is lost.
`default_nettype none

module icmp_echo_responder_unit #(
	parameter int unsigned OFFSET_WIDTH = icmp_pkg::OFFSET_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	icmp_rx_if.sink rx,
	icmp_tx_if.source tx,
	input wire logic cfg_we,
	input wire logic [icmp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [icmp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import icmp_pkg::*;

	logic [31:0] own_ip_q;
	logic [15:0] capacity_q;
	logic room;
	logic accept;
	wr_t wr;

	// configuration registers; the register index is fully decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_OWN_IP: own_ip_q <= cfg_data[31:0];
				CFG_REPLY_CAP: capacity_q <= cfg_data[15:0];
			endcase
		end
	end

	// take a byte whenever the queue can hold everything it may release
	assign rx.ready = room;
	assign accept = rx.valid && room;

	icmp_rewrite #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_rewrite (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.rx_byte(rx.rx_byte),
		.rx_last(rx.rx_last),
		.own_ip(own_ip_q),
		.capacity(capacity_q),
		.wr(wr)
	);

	icmp_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.room(room),
		.tx(tx)
	);

endmodule

`default_nettype wire

[design/icmp_rewrite.sv]
`default_nettype none

module icmp_rewrite #(
	parameter int unsigned OFFSET_WIDTH = icmp_pkg::OFFSET_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic [7:0] rx_byte,
	input wire logic rx_last,
	input wire logic [31:0] own_ip,
	input wire logic [15:0] capacity,
	output icmp_pkg::wr_t wr
);
	import icmp_pkg::*;

	localparam int unsigned OW = OFFSET_WIDTH;
	localparam logic [OW-1:0] O_TLEN_HI = OW'(OFF_TLEN_HI);
	localparam logic [OW-1:0] O_TLEN_LO = OW'(OFF_TLEN_LO);
	localparam logic [OW-1:0] O_SRC_FIRST = OW'(OFF_SRC_FIRST);
	localparam logic [OW-1:0] O_SRC_LAST = OW'(OFF_SRC_LAST);
	localparam logic [OW-1:0] O_DST_FIRST = OW'(OFF_DST_FIRST);
	localparam logic [OW-1:0] O_DST_LAST = OW'(OFF_DST_LAST);
	localparam logic [OW-1:0] O_MAX = {OW{1'b1}};

	logic [OW-1:0] offset_q;
	logic [3:0] hwords_q;
	logic [15:0] tlen_q;
	logic [31:0] src_q;
	logic dst_miss_q;
	logic type_ok_q;
	logic [7:0] held_q;
	logic held_vld_q;

	logic [3:0] hwords_n;
	logic [5:0] hlen;
	logic [5:0] hlen3;
	logic at_type;
	logic in_src;
	logic in_dst;
	logic [15:0] tlen_n;
	logic [31:0] src_n;
	logic dst_miss_n;
	logic type_ok_n;
	logic [7:0] cur;
	logic [7:0] held_out;
	logic [15:0] csum;
	logic [15:0] csum_sum;
	logic fix_csum;
	logic drop;

	always_comb begin
		hwords_n = (offset_q == '0) ? rx_byte[3:0] : hwords_q;
		hlen = {hwords_n, 2'b00};
		hlen3 = hlen + 6'd3;
		at_type = (offset_q == OW'(hlen));
		in_src = (offset_q >= O_SRC_FIRST) && (offset_q <= O_SRC_LAST);
		in_dst = (offset_q >= O_DST_FIRST) && (offset_q <= O_DST_LAST);

		tlen_n = tlen_q;
		if (offset_q == O_TLEN_HI) begin
			tlen_n = {rx_byte, tlen_q[7:0]};
		end else if (offset_q == O_TLEN_LO) begin
			tlen_n = {tlen_q[15:8], rx_byte};
		end

		src_n = src_q;
		if (in_src) begin
			unique case (offset_q[1:0])
				2'd0: src_n[31:24] = rx_byte;
				2'd1: src_n[23:16] = rx_byte;
				2'd2: src_n[15:8] = rx_byte;
				default: src_n[7:0] = rx_byte;
			endcase
		end

		dst_miss_n = dst_miss_q
			| (in_dst && (own_ip != '0) && (rx_byte != word_byte(own_ip, offset_q[1:0])));
		type_ok_n = at_type ? (rx_byte == ECHO_TYPE) : type_ok_q;

		// address rewrite wins over the ICMP edits
		priority if (in_src) begin
			cur = word_byte(own_ip, offset_q[1:0]);
		end else if (in_dst) begin
			cur = word_byte(src_q, offset_q[1:0]);
		end else if (at_type) begin
			cur = REPLY_TYPE;
		end else begin
			cur = rx_byte;
		end

		// checksum low byte arrives: patch both halves with end-around carry
		csum = {held_q, rx_byte};
		csum_sum = csum + ((csum >= CSUM_WRAP_MIN) ? CSUM_ADD_WRAP : CSUM_ADD);
		fix_csum = held_vld_q && (offset_q == OW'(hlen3)) && !in_src && !in_dst;
		held_out = held_q;
		if (fix_csum) begin
			held_out = csum_sum[15:8];
			cur = csum_sum[7:0];
		end

		drop = !type_ok_n || (tlen_n > capacity)
			|| ((own_ip != '0) && (dst_miss_n || (offset_q < O_DST_LAST)));

		wr.push_held = accept && held_vld_q;
		wr.push_cur = accept && rx_last;
		wr.held = '{tx_byte: held_out, tx_last: 1'b0, drop: 1'b0};
		wr.cur = '{tx_byte: cur, tx_last: 1'b1, drop: drop};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			hwords_q <= '0;
			tlen_q <= '0;
			src_q <= '0;
			dst_miss_q <= 1'b0;
			type_ok_q <= 1'b0;
			held_q <= '0;
			held_vld_q <= 1'b0;
		end else if (accept) begin
			if (rx_last) begin
				offset_q <= '0;
				hwords_q <= '0;
				tlen_q <= '0;
				src_q <= '0;
				dst_miss_q <= 1'b0;
				type_ok_q <= 1'b0;
				held_q <= '0;
				held_vld_q <= 1'b0;
			end else begin
				if (offset_q != O_MAX) begin
					offset_q <= offset_q + OW'(1);
				end
				hwords_q <= hwords_n;
				tlen_q <= tlen_n;
				src_q <= src_n;
				dst_miss_q <= dst_miss_n;
				type_ok_q <= type_ok_n;
				held_q <= cur;
				held_vld_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/icmp_outq.sv]
`default_nettype none
`include "icmp_echo_responder_unit_assert.svh"

module icmp_outq (
	input wire logic clk,
	input wire logic arst_n,
	input wire icmp_pkg::wr_t wr,
	output logic room,
	icmp_tx_if.source tx
);
	import icmp_pkg::*;

	localparam int unsigned PTR_W = $clog2(OUTQ_DEPTH);
	localparam int unsigned CNT_W = PTR_W + 1;

	res_t mem_q [OUTQ_DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] cnt_q;

	logic pop;
	logic [1:0] npush;
	logic [PTR_W-1:0] cur_idx;

	always_comb begin
		pop = tx.valid && tx.ready;
		npush = {1'b0, wr.push_held} + {1'b0, wr.push_cur};
		cur_idx = wr.push_held ? wp_q + PTR_W'(1) : wp_q;
	end

	// room for the two items a last byte can produce
	assign room = (cnt_q <= CNT_W'(OUTQ_DEPTH - 2));
	assign tx.valid = (cnt_q != '0);
	assign tx.tx_byte = mem_q[rp_q].tx_byte;
	assign tx.tx_last = mem_q[rp_q].tx_last;
	assign tx.drop = mem_q[rp_q].drop;

	always_ff @(posedge clk) begin
		if (wr.push_held) begin
			mem_q[wp_q] <= wr.held;
		end
		if (wr.push_cur) begin
			mem_q[cur_idx] <= wr.cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + PTR_W'(npush);
			if (pop) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(npush) - CNT_W'(pop);
		end
	end

	`ICMP_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(OUTQ_DEPTH), "output queue count over depth")
	`ICMP_ASSERT_IMPL(a_push_room, wr.push_held || wr.push_cur, cnt_q <= CNT_W'(OUTQ_DEPTH - 2), "item pushed without room")
	`ICMP_ASSERT(a_ptr_cnt, PTR_W'(wp_q - rp_q) == cnt_q[PTR_W-1:0], "queue pointers disagree with count")
	`ICMP_ASSERT_NEXT(a_two_push, wr.push_held && wr.push_cur && !pop, cnt_q == $past(cnt_q) + CNT_W'(2), "double push lost an item")

endmodule

`default_nettype wire
